### src/jms_pkg.sv
// jms_pkg: shared types and constants for the joint motion sequencer.
// Used by jms_step and joint_motion_sequencer; no dependencies.
`timescale 1ns / 1ps

package jms_pkg;

  localparam int unsigned SampleBitsDef = 12;
  localparam int unsigned DutyW         = 7;
  localparam int unsigned CfgIdxW       = 3;
  localparam logic [DutyW-1:0] DutyMax  = 7'd100;
  localparam logic [DutyW-1:0] DutyRst  = 7'd15;

  // reset levels before truncation to the sample width
  localparam int unsigned LevelRst    = 2048;
  localparam int unsigned FullFlexRst = 4095;
  localparam int unsigned FullExtRst  = 0;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_EXT  = 2'd1,
    MODE_FLEX = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CLS_FREE = 2'd0,
    CLS_EXT  = 2'd1,
    CLS_FLEX = 2'd2
  } cls_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_EXT_START  = 3'd0,
    REG_FLEX_START = 3'd1,
    REG_EXT_STOP   = 3'd2,
    REG_FLEX_STOP  = 3'd3,
    REG_FULL_EXT   = 3'd4,
    REG_FULL_FLEX  = 3'd5,
    REG_RUN_DUTY   = 3'd6
  } reg_idx_e;

  // motion state carried between samples
  typedef struct packed {
    mode_e mode;
    logic  last_dir;
  } motion_st_t;

endpackage

### src/joint_motion_sequencer.sv
// A word accepted into the input register moves on to the result register and the
// result outputs once the result register is empty or being read.
// Throughput: one sample word per cycle while results are read; input register ->
// decision -> result register, with the motion state updated as the result
// register loads. Reset: asynchronous, active low; clears valids and motion state
// and loads the register defaults. Ready is combinational from out_ready_i.
`timescale 1ns / 1ps

module joint_motion_sequencer #(
  parameter int unsigned SAMPLE_BITS = jms_pkg::SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [jms_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [SAMPLE_BITS-1:0]        cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [SAMPLE_BITS-1:0]        front_force_i,
  input  logic [SAMPLE_BITS-1:0]        back_force_i,
  input  logic [SAMPLE_BITS-1:0]        angle_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          motor_on_o,
  output logic                          motor_dir_o,
  output logic [jms_pkg::DutyW-1:0]     duty_o,
  output logic [1:0]                    limit_class_o,
  output logic [1:0]                    motion_o
);

  localparam logic [SAMPLE_BITS-1:0] LevelRst    = SAMPLE_BITS'(jms_pkg::LevelRst);
  localparam logic [SAMPLE_BITS-1:0] FullExtRst  = SAMPLE_BITS'(jms_pkg::FullExtRst);
  localparam logic [SAMPLE_BITS-1:0] FullFlexRst = SAMPLE_BITS'(jms_pkg::FullFlexRst);

  // configuration registers
  logic [SAMPLE_BITS-1:0]    ext_start_q, flex_start_q, ext_stop_q, flex_stop_q;
  logic [SAMPLE_BITS-1:0]    full_ext_q, full_flex_q;
  logic [jms_pkg::DutyW-1:0] run_duty_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_start_q  <= LevelRst;
      flex_start_q <= LevelRst;
      ext_stop_q   <= LevelRst;
      flex_stop_q  <= LevelRst;
      full_ext_q   <= FullExtRst;
      full_flex_q  <= FullFlexRst;
      run_duty_q   <= jms_pkg::DutyRst;
    end else if (cfg_valid_i) begin
      case (jms_pkg::reg_idx_e'(cfg_index_i))
        jms_pkg::REG_EXT_START:  ext_start_q  <= cfg_data_i;
        jms_pkg::REG_FLEX_START: flex_start_q <= cfg_data_i;
        jms_pkg::REG_EXT_STOP:   ext_stop_q   <= cfg_data_i;
        jms_pkg::REG_FLEX_STOP:  flex_stop_q  <= cfg_data_i;
        jms_pkg::REG_FULL_EXT:   full_ext_q   <= cfg_data_i;
        jms_pkg::REG_FULL_FLEX:  full_flex_q  <= cfg_data_i;
        jms_pkg::REG_RUN_DUTY:   run_duty_q   <= cfg_data_i[jms_pkg::DutyW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                   in_valid_q;
  logic [SAMPLE_BITS-1:0] front_q, back_q, angle_q;
  logic                   out_load;
  logic                   in_load;

  assign out_load   = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || out_load;
  assign in_load    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      front_q <= front_force_i;
      back_q  <= back_force_i;
      angle_q <= angle_sample_i;
    end
  end

  // decision
  jms_pkg::motion_st_t state_q, state_d;
  jms_pkg::cls_e       cls;

  jms_step #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_step (
    .front_force_i     (front_q),
    .back_force_i      (back_q),
    .angle_sample_i    (angle_q),
    .ext_start_level_i (ext_start_q),
    .flex_start_level_i(flex_start_q),
    .ext_stop_level_i  (ext_stop_q),
    .flex_stop_level_i (flex_stop_q),
    .full_ext_angle_i  (full_ext_q),
    .full_flex_angle_i (full_flex_q),
    .state_i           (state_q),
    .state_o           (state_d),
    .cls_o             (cls)
  );

  logic                      moving;
  logic [jms_pkg::DutyW-1:0] duty_sat;

  assign moving   = (state_d.mode != jms_pkg::MODE_IDLE);
  assign duty_sat = (run_duty_q > jms_pkg::DutyMax) ? jms_pkg::DutyMax : run_duty_q;

  // result register and motion state
  logic                      out_valid_q;
  logic                      motor_on_q, motor_dir_q;
  logic [jms_pkg::DutyW-1:0] duty_q;
  logic [1:0]                limit_class_q, motion_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      state_q.mode     <= jms_pkg::MODE_IDLE;
      state_q.last_dir <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      motor_on_q    <= moving;
      motor_dir_q   <= state_d.last_dir;
      duty_q        <= moving ? duty_sat : '0;
      limit_class_q <= cls;
      motion_q      <= state_d.mode;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign motor_on_o    = motor_on_q;
  assign motor_dir_o   = motor_dir_q;
  assign duty_o        = duty_q;
  assign limit_class_o = limit_class_q;
  assign motion_o      = motion_q;

  // checks
  a_no_direct_reverse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.mode == jms_pkg::MODE_EXT |=> state_q.mode != jms_pkg::MODE_FLEX)
    else $error("extension switched straight to flexion");

  a_on_matches_motion: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (motor_on_o == (motion_o != jms_pkg::MODE_IDLE)))
    else $error("motor enable disagrees with motion");

  a_ext_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && motion_o == jms_pkg::MODE_EXT |-> motor_dir_o)
    else $error("extending with clockwise direction");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (duty_o <= jms_pkg::DutyMax) && (motor_on_o || duty_o == '0))
    else $error("duty out of range or nonzero while idle");

endmodule

### src/jms_step.sv
// jms_step: per-sample angle classification and start/stop decision.
// Depends on jms_pkg.
`timescale 1ns / 1ps

module jms_step #(
  parameter int unsigned SAMPLE_BITS = jms_pkg::SampleBitsDef
) (
  input  logic [SAMPLE_BITS-1:0] front_force_i,
  input  logic [SAMPLE_BITS-1:0] back_force_i,
  input  logic [SAMPLE_BITS-1:0] angle_sample_i,
  input  logic [SAMPLE_BITS-1:0] ext_start_level_i,
  input  logic [SAMPLE_BITS-1:0] flex_start_level_i,
  input  logic [SAMPLE_BITS-1:0] ext_stop_level_i,
  input  logic [SAMPLE_BITS-1:0] flex_stop_level_i,
  input  logic [SAMPLE_BITS-1:0] full_ext_angle_i,
  input  logic [SAMPLE_BITS-1:0] full_flex_angle_i,
  input  jms_pkg::motion_st_t    state_i,
  output jms_pkg::motion_st_t    state_o,
  output jms_pkg::cls_e          cls_o
);

  // full extension test wins when the limits overlap
  always_comb begin
    if (angle_sample_i < full_ext_angle_i) begin
      cls_o = jms_pkg::CLS_EXT;
    end else if (angle_sample_i > full_flex_angle_i) begin
      cls_o = jms_pkg::CLS_FLEX;
    end else begin
      cls_o = jms_pkg::CLS_FREE;
    end
  end

  always_comb begin
    state_o = state_i;
    case (state_i.mode)
      jms_pkg::MODE_EXT: begin
        if (back_force_i > ext_stop_level_i || cls_o == jms_pkg::CLS_EXT) begin
          state_o.mode = jms_pkg::MODE_IDLE;
        end
      end
      jms_pkg::MODE_FLEX: begin
        if (front_force_i > flex_stop_level_i || cls_o == jms_pkg::CLS_FLEX) begin
          state_o.mode = jms_pkg::MODE_IDLE;
        end
      end
      default: begin
        state_o.mode = jms_pkg::MODE_IDLE;
        if (front_force_i > ext_start_level_i && cls_o != jms_pkg::CLS_EXT) begin
          state_o.mode     = jms_pkg::MODE_EXT;
          state_o.last_dir = 1'b1;
        end else if (back_force_i > flex_start_level_i && cls_o != jms_pkg::CLS_FLEX) begin
          state_o.mode     = jms_pkg::MODE_FLEX;
          state_o.last_dir = 1'b0;
        end
      end
    endcase
  end

endmodule

### sim/joint_motion_sequencer_tb.sv
// Self-checking testbench for joint_motion_sequencer: directed and random sample words
// across several register settings, with results checked against a cycle-free motion model.
// Depends on src/jms_pkg.sv and src/joint_motion_sequencer.sv.
`timescale 1ns / 1ps

typedef logic [jms_pkg::SampleBitsDef-1:0] sample_t;

typedef struct packed {
  logic                      motor_on;
  logic                      motor_dir;
  logic [jms_pkg::DutyW-1:0] duty;
  jms_pkg::cls_e             limit_class;
  jms_pkg::mode_e            motion;
} motor_cmd_t;

// Holds the register copy and motion state; predicts one motor command per sample word.
class motion_scoreboard;
  sample_t                   ext_start, flex_start, ext_stop, flex_stop;
  sample_t                   full_ext, full_flex;
  logic [jms_pkg::DutyW-1:0] run_duty;
  jms_pkg::mode_e            mode;
  logic                      last_dir;
  motor_cmd_t                expected_cmds[$];
  int                        errors;
  int                        checked;

  function new();
    ext_start  = sample_t'(jms_pkg::LevelRst);
    flex_start = sample_t'(jms_pkg::LevelRst);
    ext_stop   = sample_t'(jms_pkg::LevelRst);
    flex_stop  = sample_t'(jms_pkg::LevelRst);
    full_ext   = sample_t'(jms_pkg::FullExtRst);
    full_flex  = sample_t'(jms_pkg::FullFlexRst);
    run_duty   = jms_pkg::DutyRst;
    mode       = jms_pkg::MODE_IDLE;
    last_dir   = 1'b0;
    errors     = 0;
    checked    = 0;
  endfunction

  function void write_reg(logic [jms_pkg::CfgIdxW-1:0] idx, sample_t data);
    case (idx)
      jms_pkg::REG_EXT_START:  ext_start  = data;
      jms_pkg::REG_FLEX_START: flex_start = data;
      jms_pkg::REG_EXT_STOP:   ext_stop   = data;
      jms_pkg::REG_FLEX_STOP:  flex_stop  = data;
      jms_pkg::REG_FULL_EXT:   full_ext   = data;
      jms_pkg::REG_FULL_FLEX:  full_flex  = data;
      jms_pkg::REG_RUN_DUTY:   run_duty   = data[jms_pkg::DutyW-1:0];
      default: ;
    endcase
  endfunction

  function void note_sample(sample_t front, sample_t back, sample_t angle);
    jms_pkg::cls_e cls;
    motor_cmd_t    cmd;
    // full extension test first: it wins when the limits overlap
    if (angle < full_ext) cls = jms_pkg::CLS_EXT;
    else if (angle > full_flex) cls = jms_pkg::CLS_FLEX;
    else cls = jms_pkg::CLS_FREE;
    case (mode)
      jms_pkg::MODE_EXT: begin
        if (back > ext_stop || cls == jms_pkg::CLS_EXT) mode = jms_pkg::MODE_IDLE;
      end
      jms_pkg::MODE_FLEX: begin
        if (front > flex_stop || cls == jms_pkg::CLS_FLEX) mode = jms_pkg::MODE_IDLE;
      end
      default: begin
        mode = jms_pkg::MODE_IDLE;
        if (front > ext_start && cls != jms_pkg::CLS_EXT) begin
          mode     = jms_pkg::MODE_EXT;
          last_dir = 1'b1;
        end else if (back > flex_start && cls != jms_pkg::CLS_FLEX) begin
          mode     = jms_pkg::MODE_FLEX;
          last_dir = 1'b0;
        end
      end
    endcase
    cmd.motor_on    = (mode != jms_pkg::MODE_IDLE);
    cmd.motor_dir   = last_dir;
    cmd.duty        = !cmd.motor_on ? '0 :
                      (run_duty > jms_pkg::DutyMax) ? jms_pkg::DutyMax : run_duty;
    cmd.limit_class = cls;
    cmd.motion      = mode;
    expected_cmds.push_back(cmd);
  endfunction

  function void compare_field(string name, logic [6:0] want_v, logic [6:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  function void check_command(logic on, logic dir, logic [jms_pkg::DutyW-1:0] duty,
                              logic [1:0] cls, logic [1:0] motion);
    motor_cmd_t want;
    if (expected_cmds.size() == 0) begin
      $display("%0t: result word with nothing pending, expected none, actual motion %0d",
               $time, motion);
      errors++;
    end else begin
      want = expected_cmds.pop_front();
      checked++;
      compare_field("motor_on", 7'(want.motor_on), 7'(on));
      compare_field("motor_dir", 7'(want.motor_dir), 7'(dir));
      compare_field("duty", want.duty, duty);
      compare_field("limit_class", 7'(want.limit_class), 7'(cls));
      compare_field("motion", 7'(want.motion), 7'(motion));
    end
  endfunction

  function int pending();
    return expected_cmds.size();
  endfunction
endclass

module joint_motion_sequencer_tb;

  localparam int SMax = (1 << jms_pkg::SampleBitsDef) - 1;
  localparam int RandItems = 1650;
  localparam int NumPhases = 8;
  localparam logic [jms_pkg::CfgIdxW-1:0] RegUnused = 3'd7;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [jms_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  sample_t                     cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  sample_t                     front_force_i = '0;
  sample_t                     back_force_i = '0;
  sample_t                     angle_sample_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic                        motor_on_o;
  logic                        motor_dir_o;
  logic [jms_pkg::DutyW-1:0]   duty_o;
  logic [1:0]                  limit_class_o;
  logic [1:0]                  motion_o;

  motion_scoreboard sb;
  int send_idle_pct = 15;
  int recv_idle_pct = 51;
  int words_sent = 0;
  int rand_sent = 0;
  int settings_used = 0;

  joint_motion_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .front_force_i (front_force_i),
    .back_force_i  (back_force_i),
    .angle_sample_i(angle_sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .motor_on_o    (motor_on_o),
    .motor_dir_o   (motor_dir_o),
    .duty_o        (duty_o),
    .limit_class_o (limit_class_o),
    .motion_o      (motion_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_command(motor_on_o, motor_dir_o, duty_o, limit_class_o, motion_o);
      end
      if (in_valid_i && in_ready_o) sb.note_sample(front_force_i, back_force_i, angle_sample_i);
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic sample_t rand_sample();
    return sample_t'($urandom);
  endfunction

  function automatic sample_t above(sample_t lvl);
    return (int'(lvl) == SMax) ? rand_sample() : sample_t'($urandom_range(SMax, int'(lvl) + 1));
  endfunction

  function automatic sample_t at_most(sample_t lvl);
    return sample_t'($urandom_range(int'(lvl), 0));
  endfunction

  function automatic sample_t at_least(sample_t lvl);
    return sample_t'($urandom_range(SMax, int'(lvl)));
  endfunction

  function automatic sample_t below(sample_t lvl);
    return (lvl == '0) ? '0 : sample_t'($urandom_range(int'(lvl) - 1, 0));
  endfunction

  function automatic sample_t free_angle();
    if (sb.full_ext <= sb.full_flex) begin
      return sample_t'($urandom_range(int'(sb.full_flex), int'(sb.full_ext)));
    end
    return rand_sample();
  endfunction

  // valid stays up between words unless a gap is drawn
  task automatic send_sample(input sample_t front, input sample_t back, input sample_t angle);
    int gap = 0;
    while ($urandom_range(99, 0) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    front_force_i  <= front;
    back_force_i   <= back;
    angle_sample_i <= angle;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [jms_pkg::CfgIdxW-1:0] idx, input sample_t data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_config(input sample_t es, input sample_t fs, input sample_t ess,
                             input sample_t fss, input sample_t fe, input sample_t ff,
                             input sample_t duty);
    write_reg(jms_pkg::REG_EXT_START, es);
    write_reg(jms_pkg::REG_FLEX_START, fs);
    write_reg(jms_pkg::REG_EXT_STOP, ess);
    write_reg(jms_pkg::REG_FLEX_STOP, fss);
    write_reg(jms_pkg::REG_FULL_EXT, fe);
    write_reg(jms_pkg::REG_FULL_FLEX, ff);
    write_reg(jms_pkg::REG_RUN_DUTY, duty);
    write_reg(RegUnused, rand_sample());  // must be ignored
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // mostly well-formed start / run / stop sequences, some noise
  task automatic send_gesture();
    int kind = $urandom_range(9, 0);
    int lead = $urandom_range(2, 0);
    int run  = $urandom_range(6, 1);
    if (kind >= 8) begin
      repeat (lead + run) send_sample(rand_sample(), rand_sample(), rand_sample());
      rand_sent += lead + run;
    end else begin
      repeat (lead) send_sample(at_most(sb.ext_start), at_most(sb.flex_start), rand_sample());
      if (kind < 4) begin
        send_sample(above(sb.ext_start), rand_sample(), free_angle());
        repeat (run) send_sample(rand_sample(), at_most(sb.ext_stop), at_least(sb.full_ext));
        if ($urandom_range(1, 0)) begin
          send_sample(rand_sample(), above(sb.ext_stop), at_least(sb.full_ext));
        end else begin
          send_sample(rand_sample(), at_most(sb.ext_stop), below(sb.full_ext));
        end
      end else begin
        send_sample(at_most(sb.ext_start), above(sb.flex_start), free_angle());
        repeat (run) send_sample(at_most(sb.flex_stop), rand_sample(), at_most(sb.full_flex));
        if ($urandom_range(1, 0)) begin
          send_sample(above(sb.flex_stop), rand_sample(), at_most(sb.full_flex));
        end else begin
          send_sample(at_most(sb.flex_stop), rand_sample(), above(sb.full_flex));
        end
      end
      rand_sent += lead + run + 2;
    end
  endtask

  initial begin
    bit paused;
    int phase_start;
    sb = new();
    paused = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: extension wins a tie, stop word only returns to idle
    send_sample(12'd0, 12'd0, 12'd0);
    send_sample(12'd4095, 12'd4095, 12'd2048);
    send_sample(12'd4095, 12'd2048, 12'd2048);
    send_sample(12'd0, 12'd2049, 12'd0);
    send_sample(12'd0, 12'd4095, 12'd4095);
    send_sample(12'd2048, 12'd0, 12'd1000);
    send_sample(12'd2049, 12'd0, 12'd1000);
    send_sample(12'd2049, 12'd0, 12'd1000);
    drain_results();

    // angle limits active, duty above range
    load_config(12'd2048, 12'd2048, 12'd2048, 12'd2048, 12'd1000, 12'd3000, 12'd127);
    send_sample(12'd4095, 12'd0, 12'd999);
    send_sample(12'd4095, 12'd4095, 12'd999);
    send_sample(12'd0, 12'd0, 12'd3001);
    send_sample(12'd4095, 12'd0, 12'd1000);
    send_sample(12'd0, 12'd0, 12'd999);
    send_sample(12'd0, 12'd4095, 12'd3001);
    send_sample(12'd4095, 12'd0, 12'd3001);
    send_sample(12'd0, 12'd0, 12'd3001);
    send_sample(12'd0, 12'd0, 12'd4095);
    send_sample(12'd0, 12'd0, 12'd0);
    drain_results();

    // overlapping limits: the extension class wins; wide duty data is masked
    load_config(12'd2048, 12'd2048, 12'd2048, 12'd2048, 12'd3000, 12'd1000, 12'hFFF);
    send_sample(12'd0, 12'd0, 12'd2000);
    send_sample(12'd0, 12'd4095, 12'd2000);
    send_sample(12'd0, 12'd0, 12'd500);
    send_sample(12'd0, 12'd0, 12'd3500);
    send_sample(12'd0, 12'd0, 12'd3000);
    drain_results();

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: load_config(12'd2048, 12'd2048, 12'd2048, 12'd2048, 12'd0, 12'd4095, 12'd15);
        1: load_config(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
        2: load_config(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'hFFF);
        3: load_config(12'd1500, 12'd1800, 12'd2500, 12'd2600, 12'd800, 12'd3300, 12'd60);
        4: load_config(12'd1000, 12'd1200, 12'd3000, 12'd2900, 12'd3000, 12'd1000, 12'd100);
        default: begin
          load_config(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                      rand_sample(), rand_sample(), rand_sample());
        end
      endcase
      phase_start = rand_sent;
      while (rand_sent - phase_start < RandItems / NumPhases) begin
        if (rand_sent < RandItems / 3) begin
          send_idle_pct = 15;
          recv_idle_pct = 51;
        end else if (rand_sent < 2 * RandItems / 3) begin
          send_idle_pct = 51;
          recv_idle_pct = 15;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        send_gesture();
        // hold the sender once, midway through phase 3, until the pipe is empty
        if (phase == 3 && !paused && rand_sent - phase_start > RandItems / (2 * NumPhases)) begin
          drain_results();
          paused = 1'b1;
        end
      end
      drain_results();
    end

    recv_idle_pct = 0;
    drain_results();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d sample words (%0d random) under %0d register settings,",
             words_sent, rand_sent, settings_used);
    $display("%0d motor commands checked, %0d errors.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
